[hdl/b64dec_pkg.sv]
// Shared types, codes and the alphabet lookup for the base64 decoder.
// No dependencies.
`default_nettype none

package b64dec_pkg;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_DATA    = 2'd0;
    localparam t_kind KIND_END_OK  = 2'd1;
    localparam t_kind KIND_END_ERR = 2'd2;

    localparam logic [7:0] PAD_CHAR  = 8'h3D;
    localparam logic [5:0] SEXTET_62 = 6'd62;
    localparam logic [5:0] SEXTET_63 = 6'd63;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } t_sextet;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_result;

    // Map one encoded byte to its 6-bit value; valid is low outside the alphabet.
    function automatic t_sextet sextet_of(input logic [7:0] c);
        t_sextet s;
        s.valid = 1'b1;
        s.value = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s.value = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s.value = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s.value = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            s.value = SEXTET_62;
        end else if (c == 8'h2F) begin
            s.value = SEXTET_63;
        end else begin
            s.valid = 1'b0;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

[hdl/forgiving_base64_decoder.sv]
// Forgiving base64 decoder, top level: decode state and result queue.
// Depends on b64dec_pkg.
`default_nettype none

// Usage
// -----
// Slave channel (i_s_*): one encoded byte per request in tdata, tlast on the
// final byte of a string. Whitespace, non-alphabet bytes and '=' pads are
// skipped. Master channel (o_m_*): decoded bytes, tuser = kind (data,
// end ok, end error); the last byte of a string yields an end marker with
// tlast high and tdata zero. An end-error marker flags the string as malformed.
// The results of a request are written into a four-entry result queue at
// the accepting edge; o_m_* is driven straight from the queue head.
// Throughput: one input request per cycle while o_s_tready is high. A request
// makes at most two results; tready stays high while the queue has room for
// two, so the output port (one result per cycle) is what sets the rate when
// strings are short, since each end marker is a result of its own.
// Receiver stall: results wait in the queue; once fewer than two slots are
// free, o_s_tready drops until the receiver drains it. Nothing is lost.
// Reset (i_rst_n low, synchronous): decode state and queue are cleared,
// any queued results are dropped.
module forgiving_base64_decoder (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_tvalid,
    output logic                o_s_tready,
    input  wire  [7:0]          i_s_tdata,   // [7:0] in_byte
    input  wire                 i_s_tlast,   // is_last
    output logic                o_m_tvalid,
    input  wire                 i_m_tready,
    output logic [7:0]          o_m_tdata,   // [7:0] out_byte
    output b64dec_pkg::t_kind   o_m_tuser,   // [1:0] out_kind
    output logic                o_m_tlast    // out_last
);
    import b64dec_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);

    // decode state
    logic [1:0] r_phase, n_phase;
    logic [7:0] r_partial, n_partial;
    logic       r_pad_pending, n_pad_pending;
    logic       r_err, n_err;

    // result queue
    t_result          r_q [QDEPTH];
    logic [QPW-1:0]   r_wr, r_rd;
    logic [QPW:0]     r_count;

    logic       in_acc, out_acc;
    t_sextet    sx;
    logic       emit_data;
    logic [7:0] data_byte;
    t_result    res0, res1;
    logic [1:0] n_push;

    assign in_acc  = i_s_tvalid && o_s_tready;
    assign out_acc = o_m_tvalid && i_m_tready;
    assign sx      = sextet_of(i_s_tdata);

    // room for the worst case of two results
    assign o_s_tready = (r_count <= (QPW+1)'(QDEPTH - 2));

    always_comb begin
        n_phase       = r_phase;
        n_partial     = r_partial;
        n_pad_pending = r_pad_pending;
        n_err         = r_err;
        emit_data     = 1'b0;
        data_byte     = '0;
        if (!r_err) begin
            if (i_s_tdata == PAD_CHAR) begin
                if (r_phase == 2'd1) begin
                    n_pad_pending = 1'b1;
                    if (i_s_tlast) n_err = 1'b1;
                end
            end else if (r_pad_pending) begin
                n_err = 1'b1;   // pad at phase one not followed by a second pad
            end else if (sx.valid) begin
                n_phase = r_phase + 2'd1;
                unique case (r_phase)
                    2'd0: begin
                        n_partial = {sx.value, 2'b00};
                    end
                    2'd1: begin
                        emit_data = 1'b1;
                        data_byte = r_partial | {6'd0, sx.value[5:4]};
                        n_partial = {sx.value[3:0], 4'd0};
                    end
                    2'd2: begin
                        emit_data = 1'b1;
                        data_byte = r_partial | {4'd0, sx.value[5:2]};
                        n_partial = {sx.value[1:0], 6'd0};
                    end
                    default: begin
                        emit_data = 1'b1;
                        data_byte = r_partial | {2'd0, sx.value};
                        n_partial = '0;
                    end
                endcase
            end
        end
    end

    // order results: data byte first, end marker second
    always_comb begin
        t_result term;
        term.kind = n_err ? KIND_END_ERR : KIND_END_OK;
        term.data = '0;
        term.last = 1'b1;
        res0.kind = KIND_DATA;
        res0.data = data_byte;
        res0.last = 1'b0;
        res1      = term;
        if (!emit_data) res0 = term;
        n_push = {1'b0, emit_data} + {1'b0, i_s_tlast};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= '0;
            r_partial     <= '0;
            r_pad_pending <= 1'b0;
            r_err         <= 1'b0;
        end else if (in_acc) begin
            if (i_s_tlast) begin
                r_phase       <= '0;
                r_partial     <= '0;
                r_pad_pending <= 1'b0;
                r_err         <= 1'b0;
            end else begin
                r_phase       <= n_phase;
                r_partial     <= n_partial;
                r_pad_pending <= n_pad_pending;
                r_err         <= n_err;
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (in_acc && (n_push != 2'd0)) begin
            r_q[r_wr] <= res0;
        end
        if (in_acc && (n_push == 2'd2)) begin
            r_q[r_wr + QPW'(1)] <= res1;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (in_acc) r_wr <= r_wr + QPW'(n_push);
            if (out_acc) r_rd <= r_rd + QPW'(1);
            r_count <= r_count + (in_acc ? (QPW+1)'(n_push) : '0)
                               - (out_acc ? (QPW+1)'(1) : '0);
        end
    end

    assign o_m_tvalid = (r_count != '0);
    assign o_m_tdata  = r_q[r_rd].data;
    assign o_m_tuser  = r_q[r_rd].kind;
    assign o_m_tlast  = r_q[r_rd].last;

    // queue never overfills
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPW+1)'(QDEPTH))
        else $error("result queue overflow");

    // a pending pad only exists at phase one
    a_pad_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pad_pending |-> (r_phase == 2'd1))
        else $error("pad pending outside phase one");

    // end of string returns decode state to reset
    a_string_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_s_tlast) |=> (r_phase == 2'd0 && !r_pad_pending && !r_err))
        else $error("state not cleared after last byte");

    // end markers carry a zero byte and never the data kind
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tdata == 8'd0 && o_m_tuser != KIND_DATA))
        else $error("malformed end marker");

endmodule

`default_nettype wire

[sim/tb_forgiving_base64_decoder.sv]
// Self-checking testbench for forgiving_base64_decoder: streams encoded strings
// in, predicts decoded bytes and end markers, and checks every output request.
// Depends on b64dec_pkg and hdl/forgiving_base64_decoder.sv.
`default_nettype none

module tb_forgiving_base64_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import b64dec_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 1900;

    // Decode predictor and store of expected output requests.
    class decode_board;
        bit [1:0]   phase;
        bit [7:0]   partial;
        bit         pad_wait;
        bit         failed_str;
        t_result    expected_q[$];
        int         errors;

        // Bit 6 set means the byte is outside the alphabet.
        function bit [6:0] alpha_value(bit [7:0] c);
            if (c >= "A" && c <= "Z") return {1'b0, 6'(c - "A")};
            if (c >= "a" && c <= "z") return {1'b0, 6'(c - "a" + 26)};
            if (c >= "0" && c <= "9") return {1'b0, 6'(c - "0" + 52)};
            if (c == "+") return 7'd62;
            if (c == "/") return 7'd63;
            return 7'h40;
        endfunction

        function void push_data(bit [7:0] b);
            t_result r;
            r.kind = KIND_DATA;
            r.data = b;
            r.last = 1'b0;
            expected_q.push_back(r);
        endfunction

        // One accepted input request: update state and queue what it yields.
        function void add_request(bit [7:0] c, bit last);
            bit [6:0] s;
            t_result  r;
            if (!failed_str) begin
                if (c == PAD_CHAR) begin
                    // pad at phase one arms the second-pad requirement
                    if (phase == 2'd1) begin
                        pad_wait = 1'b1;
                        if (last) failed_str = 1'b1;
                    end
                end else if (pad_wait) begin
                    failed_str = 1'b1;
                end else begin
                    s = alpha_value(c);
                    if (!s[6]) begin
                        case (phase)
                            2'd0: partial = {s[5:0], 2'b00};
                            2'd1: begin
                                push_data(partial | {6'b0, s[5:4]});
                                partial = {s[3:0], 4'b0};
                            end
                            2'd2: begin
                                push_data(partial | {4'b0, s[5:2]});
                                partial = {s[1:0], 6'b0};
                            end
                            default: begin
                                push_data(partial | {2'b0, s[5:0]});
                                partial = 8'h00;
                            end
                        endcase
                        phase = phase + 2'd1;
                    end
                end
            end
            if (last) begin
                r.kind = failed_str ? KIND_END_ERR : KIND_END_OK;
                r.data = 8'h00;
                r.last = 1'b1;
                expected_q.push_back(r);
                phase      = 2'd0;
                partial    = 8'h00;
                pad_wait   = 1'b0;
                failed_str = 1'b0;
            end
        endfunction

        function void check_result(t_kind kind, bit [7:0] data, bit last);
            t_result e;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result kind=%0d data=%02h last=%0b",
                             $realtime, kind, data, last);
                return;
            end
            e = expected_q.pop_front();
            if (e.kind !== kind || e.data !== data || e.last !== last) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: exp kind/data/last=%0d/%02h/%0b got %0d/%02h/%0b",
                             $realtime, e.kind, e.data, e.last, kind, data, last);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;     // [7:0] in_byte
    logic        i_s_tlast;     // is_last
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;     // [7:0] out_byte
    t_kind       o_m_tuser;     // [1:0] out_kind
    logic        o_m_tlast;     // out_last

    forgiving_base64_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    decode_board board = new();

    int          cycles;
    int          tx_gap_max;
    int          rx_stall_max;
    int          rx_hold;
    bit          rst_done;
    logic [7:0]  str_q[$];

    always #5 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Monitor: values seen here are the ones present before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                board.add_request(i_s_tdata, i_s_tlast);
            if (o_m_tvalid && i_m_tready)
                board.check_result(o_m_tuser, o_m_tdata, o_m_tlast);
        end
    end

    // Receiver: random stalls per result, plus an optional long hold-off.
    initial begin : rx_proc
        int stall;
        wait (rst_done);
        forever begin
            if (rx_hold > 0) begin
                @(negedge i_clk) i_m_tready <= 1'b0;
                repeat (rx_hold - 1) @(negedge i_clk);
                rx_hold = 0;
            end else begin
                stall = (rx_stall_max == 0) ? 0 : $urandom_range(0, rx_stall_max);
                if (stall > 0) begin
                    @(negedge i_clk) i_m_tready <= 1'b0;
                    repeat (stall - 1) @(negedge i_clk);
                end
            end
            @(negedge i_clk) i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    // One input request; valid stays high after acceptance unless a gap follows.
    task automatic send_request(input logic [7:0] b, input logic last);
        int gap;
        gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            @(negedge i_clk) i_s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Sends str_q as one string, tlast on its final byte, then empties it.
    task automatic send_string();
        foreach (str_q[i])
            send_request(str_q[i], i == str_q.size() - 1);
        str_q.delete();
    endtask

    function automatic void add_text(string t);
        foreach (t[i]) str_q.push_back(t[i]);
    endfunction

    function automatic logic [7:0] alpha_char(int idx);
        if (idx < 26) return 8'("A" + idx);
        if (idx < 52) return 8'("a" + idx - 26);
        if (idx < 62) return 8'("0" + idx - 52);
        return (idx == 62) ? 8'h2B : 8'h2F;
    endfunction

    function automatic logic [7:0] space_char();
        case ($urandom_range(0, 3))
            0: return 8'h20;
            1: return 8'h09;
            2: return 8'h0A;
            default: return 8'h0D;
        endcase
    endfunction

    // Builds one random string into str_q; returns its length in bytes.
    function automatic int build_string();
        int style;
        int quads;
        int rem;
        int len;
        style = $urandom_range(0, 9);
        if (style <= 5) begin
            // well-formed: quartets, optional tail and proper padding
            quads = $urandom_range(0, 5);
            rem   = $urandom_range(0, 3);
            repeat (quads * 4 + rem) begin
                if ($urandom_range(0, 9) == 0) str_q.push_back(space_char());
                str_q.push_back(alpha_char($urandom_range(0, 63)));
            end
            if (rem != 0 && $urandom_range(0, 3) != 0) begin
                str_q.push_back(PAD_CHAR);
                if (rem != 3) str_q.push_back(PAD_CHAR);
            end
            if (str_q.size() == 0) str_q.push_back(alpha_char($urandom_range(0, 63)));
            return str_q.size();
        end
        len = $urandom_range(1, 16);
        if (style <= 7) begin
            // noise: any byte value
            repeat (len) str_q.push_back(8'($urandom_range(0, 255)));
            return len;
        end
        // broken: pads dropped in at random places
        repeat (len) begin
            case ($urandom_range(0, 9))
                0, 1:    str_q.push_back(PAD_CHAR);
                2:       str_q.push_back(space_char());
                default: str_q.push_back(alpha_char($urandom_range(0, 63)));
            endcase
        end
        return len;
    endfunction

    initial begin : main_proc
        int  sent;
        bit  squeezed;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = 8'h00;
        i_s_tlast    = 1'b0;
        i_m_tready   = 1'b0;
        cycles       = 0;
        rx_hold      = 0;
        tx_gap_max   = 0;
        rx_stall_max = 0;
        sent         = 0;
        squeezed     = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done = 1'b1;

        // Directed strings
        tx_gap_max   = 2;
        rx_stall_max = 2;
        add_text("Zm9v");                   // full quartet
        send_string();
        add_text("+/==");                   // 62, 63 and pads at phase two
        send_string();
        str_q.push_back(8'h00);             // skipped extremes around a pad pair
        add_text("Q");
        str_q.push_back(8'hFF);
        add_text("==");
        send_string();
        add_text("Q= A");                   // pad at phase one, then whitespace
        send_string();
        add_text("Q=");                     // pad at phase one as last byte
        send_string();
        add_text("9");                      // '9' decodes to 61, not a pad
        send_string();
        add_text("az09\t");
        send_string();

        // Random strings
        while (sent < ITEM_TARGET) begin
            if ($urandom_range(0, 14) == 0) begin
                case ($urandom_range(0, 3))
                    0, 1:    tx_gap_max = 0;
                    2:       tx_gap_max = 4;
                    default: tx_gap_max = 16;
                endcase
                case ($urandom_range(0, 3))
                    0, 1:    rx_stall_max = 0;
                    2:       rx_stall_max = 4;
                    default: rx_stall_max = 16;
                endcase
            end
            if (!squeezed && sent > ITEM_TARGET / 2) begin
                // long receiver hold-off while input runs back to back
                squeezed   = 1'b1;
                tx_gap_max = 0;
                rx_hold    = 400;
                repeat (12) begin
                    sent += build_string();
                    send_string();
                end
                // pause input until the decoder has drained
                @(negedge i_clk) i_s_tvalid <= 1'b0;
                while (board.pending() != 0) @(posedge i_clk);
            end
            sent += build_string();
            send_string();
        end
        @(negedge i_clk) i_s_tvalid <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (board.errors == 0 && board.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
hdl/b64dec_pkg.sv
hdl/forgiving_base64_decoder.sv
sim/tb_forgiving_base64_decoder.sv
